/* sv/pfa_pkg.sv */
// shared types and constants of the page frame allocator
package pfa_pkg;

    localparam int FRAME_COUNT_DEF = 64;
    localparam int PAGE_BITS_DEF   = 20;

    // fixed field widths of the stream payloads
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 6;
    localparam int PAGE_W   = 20;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 40;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_REASSIGN = 2'd2,
        OP_QUERY    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

endpackage

/* sv/page_frame_allocator.sv */
// page frame allocator built on a stack of free frame numbers
//
// Requests arrive on the s_axis channel, one transaction per operation:
// allocate, free, reassign page number or query frame. Every request gives
// exactly one result transaction on m_axis, in request order, carrying the
// status, the frame, its page number and busy mark, and the count of frames
// in use after the operation.
// The request register also captures the free stack and page table reads, and
// the result register holds the outcome that m_axis presents. One request is
// accepted every cycle while m_axis does not stall; the single stack pop or
// push and single page table access per request set that rate, with
// write-to-read forwarding between consecutive requests.
// After reset all frames are free with frame 0 on top of the stack, no frame
// is busy and all page numbers read as zero; per-entry written bits take the
// place of a clearing pass, so requests are taken at once.
// When the receiver stalls, the result register holds its transaction, the
// request register fills, and then s_axis_tready drops until m_axis drains.
module page_frame_allocator #(
    parameter int FRAME_COUNT = pfa_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = pfa_pkg::PAGE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // op[1:0], frame_index[7:2], page_number[27:8], zero[31:28]
    input  logic [pfa_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // status[1:0], granted_frame[7:2], stored_page[27:8], frame_busy[28],
    // frames_in_use[35:29], zero[39:36]
    output logic [pfa_pkg::OUT_W-1:0] m_axis_tdata
);
    import pfa_pkg::*;

    localparam int FRAME_W = $clog2(FRAME_COUNT);
    localparam int DEPTH_W = $clog2(FRAME_COUNT + 1);

    // stack and page table storage
    logic [FRAME_W-1:0]   fl_mem [FRAME_COUNT];
    logic [PAGE_BITS-1:0] pg_mem [FRAME_COUNT];

    // control state
    logic [FRAME_COUNT-1:0] fl_written_reg;
    logic [FRAME_COUNT-1:0] pg_written_reg;
    logic [FRAME_COUNT-1:0] busy_reg;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic [DEPTH_W-1:0]    used_reg, used_next;
    logic                  s1_valid_reg;
    logic                  out_valid_reg;

    // request stage payload
    op_t                   op_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [FRAME_W-1:0]    fl_rd_reg;
    logic [PAGE_BITS-1:0]  pg_rd_reg;
    logic [OUT_W-1:0]      out_data_reg;

    logic                  b_fire;
    logic                  s_accept;
    logic [INDEX_W-1:0]    in_idx;
    logic [FRAME_W-1:0]    rd_fl_addr;
    logic [FRAME_W-1:0]    rd_pg_addr;
    logic [DEPTH_W-1:0]    depth_after;

    logic [FRAME_W-1:0]    idx_w;
    logic                  idx_ok;
    logic [FRAME_W-1:0]    pop_addr;
    logic [FRAME_W-1:0]    push_addr;
    logic [FRAME_W-1:0]    pop_frame;
    logic                  busy_cur;
    logic [PAGE_BITS-1:0]  page_cur;

    logic                  fl_we;
    logic [FRAME_W-1:0]    fl_wa;
    logic [FRAME_W-1:0]    fl_wd;
    logic                  pg_we;
    logic [FRAME_W-1:0]    pg_wa;
    logic [PAGE_BITS-1:0]  pg_wd;
    logic                  busy_we;
    logic [FRAME_W-1:0]    busy_wa;
    logic                  busy_wd;

    status_t               res_status;
    logic [INDEX_W-1:0]    res_frame;
    logic [PAGE_BITS-1:0]  res_page;
    logic                  res_busy;

    assign b_fire        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || b_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign in_idx      = s_axis_tdata[OP_W +: INDEX_W];
    assign depth_after = b_fire ? depth_next : depth_reg;
    // the next pop reads the top left behind by the request in flight
    assign rd_fl_addr  = FRAME_W'(depth_after - 1'b1);
    assign rd_pg_addr  = FRAME_W'(in_idx);

    // operation logic on the registered request
    always_comb
    begin
        idx_w     = FRAME_W'(idx_reg);
        idx_ok    = 32'(idx_reg) < 32'(FRAME_COUNT);
        pop_addr  = FRAME_W'(depth_reg - 1'b1);
        push_addr = FRAME_W'(depth_reg);
        pop_frame = fl_written_reg[pop_addr] ? fl_rd_reg
                                             : FRAME_W'(FRAME_COUNT - 1) - pop_addr;
        busy_cur  = idx_ok ? busy_reg[idx_w] : 1'b0;
        page_cur  = (idx_ok && pg_written_reg[idx_w]) ? pg_rd_reg : '0;

        depth_next = depth_reg;
        used_next  = used_reg;
        fl_we      = 1'b0;
        fl_wa      = push_addr;
        fl_wd      = idx_w;
        pg_we      = 1'b0;
        pg_wa      = idx_w;
        pg_wd      = page_reg;
        busy_we    = 1'b0;
        busy_wa    = idx_w;
        busy_wd    = 1'b0;
        res_status = ST_OK;
        res_frame  = idx_reg;
        res_page   = page_cur;
        res_busy   = busy_cur;

        case (op_reg)
            OP_ALLOC:
            begin
                if (depth_reg == '0)
                begin
                    res_status = ST_FULL;
                    res_frame  = '0;
                    res_page   = '0;
                    res_busy   = 1'b0;
                end
                else
                begin
                    depth_next = depth_reg - 1'b1;
                    used_next  = used_reg + 1'b1;
                    busy_we    = 1'b1;
                    busy_wa    = pop_frame;
                    busy_wd    = 1'b1;
                    pg_we      = 1'b1;
                    pg_wa      = pop_frame;
                    res_frame  = INDEX_W'(pop_frame);
                    res_page   = page_reg;
                    res_busy   = 1'b1;
                end
            end
            OP_FREE:
            begin
                if (!idx_ok || !busy_cur || 32'(depth_reg) >= 32'(FRAME_COUNT))
                begin
                    res_status = ST_IGNORED;
                end
                else
                begin
                    busy_we    = 1'b1;
                    fl_we      = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - 1'b1;
                    end
                    res_busy   = 1'b0;
                end
            end
            OP_REASSIGN:
            begin
                if (idx_ok)
                begin
                    pg_we    = 1'b1;
                    res_page = page_reg;
                end
            end
            OP_QUERY:
            begin
                res_status = ST_OK;
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // memories with registered reads, forwarding the write of the request in flight
    always_ff @(posedge clk)
    begin
        if (b_fire && fl_we)
        begin
            fl_mem[fl_wa] <= fl_wd;
        end
        if (b_fire && pg_we)
        begin
            pg_mem[pg_wa] <= pg_wd;
        end
        if (s_accept)
        begin
            fl_rd_reg <= (b_fire && fl_we && fl_wa == rd_fl_addr) ? fl_wd
                                                                  : fl_mem[rd_fl_addr];
            pg_rd_reg <= (b_fire && pg_we && pg_wa == rd_pg_addr) ? pg_wd
                                                                  : pg_mem[rd_pg_addr];
        end
    end

    // request and result payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg   <= op_t'(s_axis_tdata[OP_W-1:0]);
            idx_reg  <= in_idx;
            page_reg <= PAGE_BITS'(s_axis_tdata[OP_W + INDEX_W +: PAGE_W]);
        end
        if (b_fire)
        begin
            out_data_reg <= {4'b0, COUNT_W'(used_next), res_busy, PAGE_W'(res_page),
                             res_frame, res_status};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            depth_reg      <= DEPTH_W'(FRAME_COUNT);
            used_reg       <= '0;
            busy_reg       <= '0;
            fl_written_reg <= '0;
            pg_written_reg <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (b_fire)
            begin
                out_valid_reg <= 1'b1;
                depth_reg     <= depth_next;
                used_reg      <= used_next;
                if (busy_we)
                begin
                    busy_reg[busy_wa] <= busy_wd;
                end
                if (fl_we)
                begin
                    fl_written_reg[fl_wa] <= 1'b1;
                end
                if (pg_we)
                begin
                    pg_written_reg[pg_wa] <= 1'b1;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
